// ----- hw/rtl/olir_pkg.sv -----
package olir_pkg;

   localparam int CAPACITY      = 16;
   localparam int ELEMENT_WIDTH = 32;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int POS_W = 4;
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef logic [ELEMENT_WIDTH-1:0] elem_type;
   typedef logic [CNT_W-1:0]         cnt_type;

   typedef enum logic [2:0] {
      FN_PUSH         = 3'd0,
      FN_POP          = 3'd1,
      FN_INSERT       = 3'd2,
      FN_REMOVE_AT    = 3'd3,
      FN_REMOVE_FIRST = 3'd4,
      FN_REMOVE_ALL   = 3'd5,
      FN_CLEAR        = 3'd6,
      FN_READ_AT      = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      func_type    func;
      logic [3:0]  position;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [4:0]  count;
      logic [31:0] read_value;
      logic [4:0]  removed;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic drop;
   } dp_cmd_type;

   typedef struct packed {
      logic match_op;
      logic all_op;
      logic any_match;
   } dp_stat_type;

endpackage

// ----- hw/rtl/olir_ctrl.sv -----
module olir_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output logic                  rsp_valid,
   output olir_pkg::dp_cmd_type  cmd,
   input  olir_pkg::dp_stat_type stat
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_SCAN = 4'b0100,
      S_RESP = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.match_op) begin
               state_in = S_SCAN;
            end else begin
               cmd.exec = 1'b1;
               state_in = S_RESP;
            end
         end
         S_SCAN: begin
            cmd.drop = 1'b1;
            if (!stat.all_op || !stat.any_match) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("accepted item did not raise busy");

   a_resp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("result strobe not followed by idle");

endmodule

// ----- hw/rtl/olir_dp.sv -----
module olir_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  olir_pkg::req_type     req_data,
   input  olir_pkg::dp_cmd_type  cmd,
   output olir_pkg::dp_stat_type stat,
   output olir_pkg::rsp_type     rsp_data
);

   olir_pkg::elem_type entries_ff [olir_pkg::CAPACITY];
   olir_pkg::elem_type entries_in [olir_pkg::CAPACITY];
   olir_pkg::cnt_type  fill_ff, fill_in;
   olir_pkg::cnt_type  removed_ff, removed_in;
   olir_pkg::req_type  req_ff, req_in;
   olir_pkg::status_type status_ff, status_in;
   logic [31:0]        rdata_ff, rdata_in;

   logic [olir_pkg::CAPACITY-1:0] match;
   logic [olir_pkg::CAPACITY-1:0] drop_mask;
   logic                          any_match;
   logic                          drop_en;
   logic                          tail_ok;
   logic                          full;
   logic                          empty;
   logic [olir_pkg::CMP_W-1:0]    pos_c;
   logic [olir_pkg::CMP_W-1:0]    fill_c;
   olir_pkg::elem_type            val;

   // parallel compare over all held cells
   always_comb begin
      val       = olir_pkg::ELEMENT_WIDTH'(req_ff.value);
      any_match = 1'b0;
      tail_ok   = 1'b1;
      for (int i = 0; i < olir_pkg::CAPACITY; i++) begin
         match[i]  = (olir_pkg::CNT_W'(i) < fill_ff) && (entries_ff[i] == val);
         any_match = any_match | match[i];
         if ((olir_pkg::CNT_W'(i) >= fill_ff) && (entries_ff[i] != '0)) begin
            tail_ok = 1'b0;
         end
      end
   end

   assign pos_c  = olir_pkg::CMP_W'(req_ff.position);
   assign fill_c = olir_pkg::CMP_W'(fill_ff);
   assign full   = (fill_ff >= olir_pkg::CNT_W'(olir_pkg::CAPACITY));
   assign empty  = (fill_ff == '0);

   always_comb begin
      logic run;
      entries_in = entries_ff;
      fill_in    = fill_ff;
      removed_in = removed_ff;
      status_in  = status_ff;
      rdata_in   = rdata_ff;
      req_in     = req_ff;
      drop_mask  = '0;
      drop_en    = 1'b0;
      run        = 1'b0;

      if (cmd.load) begin
         req_in     = req_data;
         status_in  = olir_pkg::ST_OK;
         rdata_in   = '0;
         removed_in = '0;
      end else if (cmd.exec) begin
         unique case (req_ff.func)
            olir_pkg::FN_PUSH: begin
               if (full) begin
                  status_in = olir_pkg::ST_FULL;
               end else begin
                  for (int i = 0; i < olir_pkg::CAPACITY; i++) begin
                     if (olir_pkg::CNT_W'(i) == fill_ff) begin
                        entries_in[i] = val;
                     end
                  end
                  fill_in = fill_ff + olir_pkg::CNT_W'(1);
               end
            end
            olir_pkg::FN_POP: begin
               if (empty) begin
                  status_in = olir_pkg::ST_EMPTY;
               end else begin
                  drop_en = 1'b1;
                  for (int i = 0; i < olir_pkg::CAPACITY; i++) begin
                     drop_mask[i] = (olir_pkg::CNT_W'(i) >= fill_ff - olir_pkg::CNT_W'(1));
                  end
               end
            end
            olir_pkg::FN_INSERT: begin
               if (pos_c > fill_c) begin
                  status_in = olir_pkg::ST_RANGE;
               end else if (full) begin
                  status_in = olir_pkg::ST_FULL;
               end else begin
                  if (pos_c == '0) begin
                     entries_in[0] = val;
                  end
                  for (int i = 1; i < olir_pkg::CAPACITY; i++) begin
                     if (olir_pkg::CMP_W'(i) == pos_c) begin
                        entries_in[i] = val;
                     end else if ((olir_pkg::CMP_W'(i) > pos_c) &&
                                  (olir_pkg::CMP_W'(i) <= fill_c)) begin
                        entries_in[i] = entries_ff[i-1];
                     end
                  end
                  fill_in = fill_ff + olir_pkg::CNT_W'(1);
               end
            end
            olir_pkg::FN_REMOVE_AT: begin
               if (empty) begin
                  status_in = olir_pkg::ST_EMPTY;
               end else if (pos_c >= fill_c) begin
                  status_in = olir_pkg::ST_RANGE;
               end else begin
                  drop_en = 1'b1;
                  for (int i = 0; i < olir_pkg::CAPACITY; i++) begin
                     drop_mask[i] = (olir_pkg::CMP_W'(i) >= pos_c);
                  end
               end
            end
            olir_pkg::FN_CLEAR: begin
               removed_in = fill_ff;
               fill_in    = '0;
               for (int i = 0; i < olir_pkg::CAPACITY; i++) begin
                  entries_in[i] = '0;
               end
            end
            olir_pkg::FN_READ_AT: begin
               if (pos_c >= fill_c) begin
                  status_in = olir_pkg::ST_RANGE;
               end else begin
                  rdata_in = 32'(entries_ff[olir_pkg::IDX_W'(req_ff.position)]);
               end
            end
            default: begin
            end
         endcase
      end else if (cmd.drop) begin
         if (any_match) begin
            drop_en = 1'b1;
            for (int i = 0; i < olir_pkg::CAPACITY; i++) begin
               run          = run | match[i];
               drop_mask[i] = run;
            end
         end
      end

      // close the gap: cells from the dropped slot take their right neighbor
      if (drop_en) begin
         for (int i = 0; i < olir_pkg::CAPACITY - 1; i++) begin
            if (drop_mask[i]) begin
               entries_in[i] = entries_ff[i+1];
            end
         end
         if (drop_mask[olir_pkg::CAPACITY-1]) begin
            entries_in[olir_pkg::CAPACITY-1] = '0;
         end
         fill_in    = fill_ff - olir_pkg::CNT_W'(1);
         removed_in = removed_ff + olir_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         for (int i = 0; i < olir_pkg::CAPACITY; i++) begin
            entries_ff[i] <= '0;
         end
      end else begin
         fill_ff    <= fill_in;
         entries_ff <= entries_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      status_ff  <= status_in;
      rdata_ff   <= rdata_in;
      removed_ff <= removed_in;
   end

   assign stat.match_op  = (req_ff.func == olir_pkg::FN_REMOVE_FIRST) ||
                           (req_ff.func == olir_pkg::FN_REMOVE_ALL);
   assign stat.all_op    = (req_ff.func == olir_pkg::FN_REMOVE_ALL);
   assign stat.any_match = any_match;

   assign rsp_data.status     = status_ff;
   assign rsp_data.count      = 5'(fill_ff);
   assign rsp_data.read_value = rdata_ff;
   assign rsp_data.removed    = 5'(removed_ff);

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= olir_pkg::CNT_W'(olir_pkg::CAPACITY))
      else $error("fill count above capacity");

   a_tail_zero: assert property (@(posedge clock) disable iff (reset)
      tail_ok)
      else $error("nonzero cell beyond fill count");

   a_drop_fill: assert property (@(posedge clock) disable iff (reset)
      cmd.drop && any_match |=> fill_ff == $past(fill_ff) - olir_pkg::CNT_W'(1))
      else $error("match drop did not shrink list");

   a_err_hold: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && (status_in != olir_pkg::ST_OK) |=> $stable(fill_ff))
      else $error("failed request changed fill count");

endmodule

// ----- hw/rtl/ordered_list_insert_remove_core.sv -----
// ordered list of 16 values, packed from position zero
// request channel: drive req_data and raise start; the item is taken at the
// clock edge where start is high and busy is low. busy stays high until the
// result has been shown.
// result channel: rsp_valid is high for exactly one cycle with rsp_data
// (status, count, read_value, removed); the receiver cannot stall it.
// sequence: push, pop, insert, remove_at, clear and read_at pass through the
// exec and resp states and take a new item in the cycle after the result.
// remove_first_match adds the scan state; remove_all_match stays in scan
// until no entry matches, since the match-and-shift unit drops one entry per cycle.
// the core takes no new item until the result of the last one has been shown.
// reset: synchronous, clears the list to empty with every cell zero and
// returns the controller to idle; no result is pending afterward.
module ordered_list_insert_remove_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  olir_pkg::req_type req_data,
   output logic              rsp_valid,
   output olir_pkg::rsp_type rsp_data
);

   olir_pkg::dp_cmd_type  cmd;
   olir_pkg::dp_stat_type stat;

   olir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   olir_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule
